FILE: src/fbp_pkg.sv
`timescale 1ns / 1ps
package fbp_pkg;

   localparam int MAX_FRAMES = 128;
   localparam int FRAME_W    = $clog2(MAX_FRAMES);
   localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
   localparam int LIST_W     = 2;
   localparam int OP_W       = 3;

   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [LIST_W-1:0]  list_type;
   typedef logic [OP_W-1:0]    op_type;

   localparam list_type LIST_EMPTY = 2'd0;
   localparam list_type LIST_DEC   = 2'd1;
   localparam list_type LIST_READY = 2'd2;
   localparam list_type LIST_REND  = 2'd3;

   localparam op_type OP_DEC_GET = 3'd0;
   localparam op_type OP_DEC_PUT = 3'd1;
   localparam op_type OP_REN_GET = 3'd2;
   localparam op_type OP_REN_PUT = 3'd3;
   localparam op_type OP_RESET   = 3'd4;

   localparam int POOL_CAP = (MAX_FRAMES < 128) ? MAX_FRAMES : 128;
   localparam logic [7:0] POOL_LIMIT = 8'(POOL_CAP);
   localparam logic [7:0] POOL_RESET = 8'((MAX_FRAMES < 16) ? MAX_FRAMES : 16);

   typedef struct packed {
      logic      status;
      frame_type granted_frame;
      count_type empty_count;
      count_type ready_count;
      count_type decoding_count;
      count_type rendering_count;
   } rsp_type;

endpackage

FILE: src/fbp_ram.sv
`timescale 1ns / 1ps
module fbp_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/fbp_ctrl.sv
`timescale 1ns / 1ps
module fbp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               init_start,
   input  fbp_pkg::count_type pool_size,
   input  logic               req_valid,
   output logic               req_stall,
   input  fbp_pkg::op_type    req_op,
   input  fbp_pkg::frame_type req_frame,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fbp_pkg::rsp_type   rsp,
   output logic               idle
);
   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_EVAL   = 3'd3;
   localparam logic [2:0] S_LINK   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   fbp_pkg::frame_type init_cnt_ff, init_cnt_in;

   fbp_pkg::frame_type head_ff [4];
   fbp_pkg::frame_type tail_ff [4];
   fbp_pkg::count_type count_ff [4];

   fbp_pkg::op_type    op_ff;
   fbp_pkg::frame_type fr_ff;
   fbp_pkg::frame_type f_ff;
   fbp_pkg::list_type  src_ff, dst_ff;
   logic               check_ff, grant_ff, fail_ff;
   logic               link_ff;
   fbp_pkg::frame_type tail_old_ff;

   logic               rsp_valid_ff;
   fbp_pkg::rsp_type   rsp_ff;

   // memory ports
   logic               next_we, prev_we, memb_we, rd_en;
   fbp_pkg::frame_type next_wa, prev_wa, memb_wa, rd_addr;
   fbp_pkg::frame_type next_wd, prev_wd, next_rd, prev_rd;
   fbp_pkg::list_type  memb_wd, memb_rd;

   // decide stage decode
   fbp_pkg::list_type  d_src, d_dst;
   fbp_pkg::frame_type d_f;
   logic               d_fail, d_none, d_check, d_grant;

   logic take;
   assign take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      d_src   = fbp_pkg::LIST_EMPTY;
      d_dst   = fbp_pkg::LIST_EMPTY;
      d_f     = fr_ff;
      d_fail  = 1'b0;
      d_none  = 1'b0;
      d_check = 1'b0;
      d_grant = 1'b0;
      unique case (op_ff)
         fbp_pkg::OP_DEC_GET: begin
            d_src   = fbp_pkg::LIST_EMPTY;
            d_dst   = fbp_pkg::LIST_DEC;
            d_f     = head_ff[fbp_pkg::LIST_EMPTY];
            d_fail  = (count_ff[fbp_pkg::LIST_EMPTY] == '0);
            d_grant = 1'b1;
         end
         fbp_pkg::OP_DEC_PUT: begin
            d_src   = fbp_pkg::LIST_DEC;
            d_dst   = fbp_pkg::LIST_READY;
            d_fail  = ({1'b0, fr_ff} >= pool_size);
            d_check = 1'b1;
         end
         fbp_pkg::OP_REN_GET: begin
            d_src   = fbp_pkg::LIST_READY;
            d_dst   = fbp_pkg::LIST_REND;
            d_f     = head_ff[fbp_pkg::LIST_READY];
            d_fail  = (count_ff[fbp_pkg::LIST_READY] == '0);
            d_grant = 1'b1;
         end
         fbp_pkg::OP_REN_PUT: begin
            d_src   = fbp_pkg::LIST_REND;
            d_dst   = fbp_pkg::LIST_EMPTY;
            d_fail  = ({1'b0, fr_ff} >= pool_size);
            d_check = 1'b1;
         end
         fbp_pkg::OP_RESET: begin
            // drain order: rendering, then decoding, then ready
            d_dst = fbp_pkg::LIST_EMPTY;
            if (count_ff[fbp_pkg::LIST_REND] != '0) begin
               d_src = fbp_pkg::LIST_REND;
            end else if (count_ff[fbp_pkg::LIST_DEC] != '0) begin
               d_src = fbp_pkg::LIST_DEC;
            end else if (count_ff[fbp_pkg::LIST_READY] != '0) begin
               d_src = fbp_pkg::LIST_READY;
            end else begin
               d_none = 1'b1;
            end
            d_f = head_ff[d_src];
         end
         default: begin
            d_fail = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      init_cnt_in = init_cnt_ff;
      next_we = 1'b0;
      prev_we = 1'b0;
      memb_we = 1'b0;
      next_wa = init_cnt_ff;
      prev_wa = init_cnt_ff;
      memb_wa = init_cnt_ff;
      next_wd = init_cnt_ff + 1'b1;
      prev_wd = (init_cnt_ff == '0) ? '0 : init_cnt_ff - 1'b1;
      memb_wd = fbp_pkg::LIST_EMPTY;
      rd_en   = 1'b0;
      rd_addr = d_f;
      unique case (state_ff)
         S_INIT: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            memb_we = 1'b1;
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == fbp_pkg::frame_type'(fbp_pkg::MAX_FRAMES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (d_fail || d_none) begin
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (check_ff && memb_rd != src_ff) begin
               state_in = S_DONE;
            end else begin
               // unlink from source, mark new list
               next_we = (head_ff[src_ff] != f_ff);
               next_wa = prev_rd;
               next_wd = next_rd;
               prev_we = (tail_ff[src_ff] != f_ff);
               prev_wa = next_rd;
               prev_wd = prev_rd;
               memb_we = 1'b1;
               memb_wa = f_ff;
               memb_wd = dst_ff;
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            next_we = link_ff;
            next_wa = tail_old_ff;
            next_wd = f_ff;
            prev_we = link_ff;
            prev_wa = f_ff;
            prev_wd = tail_old_ff;
            state_in = (op_ff == fbp_pkg::OP_RESET) ? S_DECIDE : S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      if (init_start) begin
         state_in    = S_INIT;
         init_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         init_cnt_ff <= init_cnt_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_INIT && !init_start &&
          init_cnt_ff == fbp_pkg::frame_type'(fbp_pkg::MAX_FRAMES - 1)) begin
         for (int i = 0; i < 4; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         tail_ff[fbp_pkg::LIST_EMPTY]  <= fbp_pkg::frame_type'(pool_size - 1'b1);
         count_ff[fbp_pkg::LIST_EMPTY] <= pool_size;
      end
      if (state_ff == S_IDLE && req_valid) begin
         op_ff <= req_op;
         fr_ff <= req_frame;
      end
      if (state_ff == S_DECIDE) begin
         f_ff     <= d_f;
         src_ff   <= d_src;
         dst_ff   <= d_dst;
         check_ff <= d_check;
         grant_ff <= d_grant;
         fail_ff  <= d_fail;
      end
      if (state_ff == S_EVAL) begin
         if (check_ff && memb_rd != src_ff) begin
            fail_ff <= 1'b1;
         end else begin
            if (head_ff[src_ff] == f_ff) begin
               head_ff[src_ff] <= next_rd;
            end
            if (tail_ff[src_ff] == f_ff) begin
               tail_ff[src_ff] <= prev_rd;
            end
            count_ff[src_ff] <= count_ff[src_ff] - 1'b1;
            if (count_ff[dst_ff] == '0) begin
               head_ff[dst_ff] <= f_ff;
            end
            tail_ff[dst_ff]  <= f_ff;
            count_ff[dst_ff] <= count_ff[dst_ff] + 1'b1;
            link_ff     <= (count_ff[dst_ff] != '0);
            tail_old_ff <= tail_ff[dst_ff];
         end
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.status          <= fail_ff;
         rsp_ff.granted_frame   <= (grant_ff && !fail_ff) ? f_ff : '0;
         rsp_ff.empty_count     <= count_ff[fbp_pkg::LIST_EMPTY];
         rsp_ff.ready_count     <= count_ff[fbp_pkg::LIST_READY];
         rsp_ff.decoding_count  <= count_ff[fbp_pkg::LIST_DEC];
         rsp_ff.rendering_count <= count_ff[fbp_pkg::LIST_REND];
      end
   end

   fbp_ram #(.WIDTH(fbp_pkg::FRAME_W), .ADDR_W(fbp_pkg::FRAME_W)) u_next (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .re(rd_en), .raddr(rd_addr), .rdata(next_rd)
   );
   fbp_ram #(.WIDTH(fbp_pkg::FRAME_W), .ADDR_W(fbp_pkg::FRAME_W)) u_prev (
      .clock(clock), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
      .re(rd_en), .raddr(rd_addr), .rdata(prev_rd)
   );
   fbp_ram #(.WIDTH(fbp_pkg::LIST_W), .ADDR_W(fbp_pkg::FRAME_W)) u_memb (
      .clock(clock), .we(memb_we), .waddr(memb_wa), .wdata(memb_wd),
      .re(rd_en), .raddr(rd_addr), .rdata(memb_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign idle      = (state_ff == S_IDLE);

   logic [fbp_pkg::COUNT_W+1:0] count_sum;
   assign count_sum = {2'b0, count_ff[0]} + {2'b0, count_ff[1]} +
                      {2'b0, count_ff[2]} + {2'b0, count_ff[3]};

   a_conserve: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !init_start) |-> (count_sum == {2'b0, pool_size}))
      else $error("list counts do not add up to the pool size");

   a_fail_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |-> (rsp_ff.granted_frame == '0))
      else $error("failed item reports a granted frame");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !init_start) |=> (state_ff == S_DECIDE))
      else $error("accepted item not decoded");
endmodule

FILE: src/four_list_frame_buffer_pool_top.sv
`timescale 1ns / 1ps
// Frame buffer pool with four ordered lists (empty, decoding, ready, rendering)
// kept as doubly linked lists in link memories with one read and one write port.
// A get or put runs from accept to result through decide, memory read, unlink
// and append, and a failing item skips the steps after its check; a new item
// is accepted only once the last one is through. The reset opcode moves the
// frames back one at a time. After reset and after every pool_size write, a
// pass over all link memory entries rebuilds the link memories, during
// which no item is accepted; an item is also held off while csr_valid is high.
// Results wait in an output register, so the next item can be accepted while
// one is stalled.
module four_list_frame_buffer_pool_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_pool_size,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [6:0] req_frame_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_status,
   output logic [6:0] rsp_granted_frame,
   output logic [7:0] rsp_empty_count,
   output logic [7:0] rsp_ready_count,
   output logic [7:0] rsp_decoding_count,
   output logic [7:0] rsp_rendering_count
);
   logic [7:0] pool_ff, pool_in;
   logic       csr_we, idle, ctrl_stall;
   fbp_pkg::rsp_type rsp;

   assign csr_we = csr_valid && csr_ready;

   always_comb begin
      pool_in = csr_pool_size;
      if (pool_in == 8'd0) begin
         pool_in = 8'd1;
      end else if (pool_in > fbp_pkg::POOL_LIMIT) begin
         pool_in = fbp_pkg::POOL_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= fbp_pkg::POOL_RESET;
      end else if (csr_we) begin
         pool_ff <= pool_in;
      end
   end

   assign csr_ready = idle;
   // a pool size write wins over an item offered in the same cycle
   assign req_stall = ctrl_stall || csr_valid;

   fbp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .init_start(csr_we),
      .pool_size(fbp_pkg::count_type'(pool_ff)),
      .req_valid(req_valid),
      .req_stall(ctrl_stall),
      .req_op(req_opcode),
      .req_frame(req_frame_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp(rsp),
      .idle(idle)
   );

   assign rsp_status          = rsp.status;
   assign rsp_granted_frame   = rsp.granted_frame;
   assign rsp_empty_count     = rsp.empty_count;
   assign rsp_ready_count     = rsp.ready_count;
   assign rsp_decoding_count  = rsp.decoding_count;
   assign rsp_rendering_count = rsp.rendering_count;
endmodule

FILE: tb/four_list_frame_buffer_pool_top_tb.sv
`timescale 1ns / 1ps
module four_list_frame_buffer_pool_top_tb;

   localparam int WATCHDOG_LIMIT = 20000;

   // behavioral copy of the pool, lists kept as plain queues
   class pool_scoreboard;
      fbp_pkg::frame_type lists[4][$];
      int                 pool_frames;
      fbp_pkg::rsp_type   pending[$];
      int                 errors;
      int                 checked;
      int                 failures_seen;

      function void rebuild(logic [7:0] value);
         int v;
         v = value;
         if (v < 1) v = 1;
         if (v > fbp_pkg::POOL_CAP) v = fbp_pkg::POOL_CAP;
         pool_frames = v;
         for (int l = 0; l < 4; l++) lists[l].delete();
         for (int i = 0; i < v; i++)
            lists[fbp_pkg::LIST_EMPTY].push_back(fbp_pkg::frame_type'(i));
      endfunction

      function int find_in(int l, fbp_pkg::frame_type f);
         for (int i = 0; i < lists[l].size(); i++)
            if (lists[l][i] == f) return i;
         return -1;
      endfunction

      function void note_request(fbp_pkg::op_type op, fbp_pkg::frame_type f);
         fbp_pkg::rsp_type r;
         int pos;
         r = '0;
         case (op) inside
            fbp_pkg::OP_DEC_GET, fbp_pkg::OP_REN_GET: begin
               int src, dst;
               src = (op == fbp_pkg::OP_DEC_GET) ? fbp_pkg::LIST_EMPTY : fbp_pkg::LIST_READY;
               dst = (op == fbp_pkg::OP_DEC_GET) ? fbp_pkg::LIST_DEC : fbp_pkg::LIST_REND;
               if (lists[src].size() == 0) r.status = 1'b1;
               else begin
                  r.granted_frame = lists[src].pop_front();
                  lists[dst].push_back(r.granted_frame);
               end
            end
            fbp_pkg::OP_DEC_PUT, fbp_pkg::OP_REN_PUT: begin
               int src, dst;
               src = (op == fbp_pkg::OP_DEC_PUT) ? fbp_pkg::LIST_DEC : fbp_pkg::LIST_REND;
               dst = (op == fbp_pkg::OP_DEC_PUT) ? fbp_pkg::LIST_READY : fbp_pkg::LIST_EMPTY;
               pos = find_in(src, f);
               if (pos < 0) r.status = 1'b1;
               else begin
                  lists[src].delete(pos);
                  lists[dst].push_back(f);
               end
            end
            fbp_pkg::OP_RESET: begin
               foreach (lists[fbp_pkg::LIST_REND][i])
                  lists[fbp_pkg::LIST_EMPTY].push_back(lists[fbp_pkg::LIST_REND][i]);
               foreach (lists[fbp_pkg::LIST_DEC][i])
                  lists[fbp_pkg::LIST_EMPTY].push_back(lists[fbp_pkg::LIST_DEC][i]);
               foreach (lists[fbp_pkg::LIST_READY][i])
                  lists[fbp_pkg::LIST_EMPTY].push_back(lists[fbp_pkg::LIST_READY][i]);
               lists[fbp_pkg::LIST_REND].delete();
               lists[fbp_pkg::LIST_DEC].delete();
               lists[fbp_pkg::LIST_READY].delete();
            end
            default: r.status = 1'b1;
         endcase
         if (r.status) failures_seen++;
         r.empty_count     = fbp_pkg::count_type'(lists[fbp_pkg::LIST_EMPTY].size());
         r.ready_count     = fbp_pkg::count_type'(lists[fbp_pkg::LIST_READY].size());
         r.decoding_count  = fbp_pkg::count_type'(lists[fbp_pkg::LIST_DEC].size());
         r.rendering_count = fbp_pkg::count_type'(lists[fbp_pkg::LIST_REND].size());
         pending.push_back(r);
      endfunction

      function void check_report(fbp_pkg::rsp_type got);
         fbp_pkg::rsp_type exp;
         checked++;
         if (pending.size() == 0) begin
            $error("unexpected result item");
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $error("status exp %0d got %0d", exp.status, got.status); errors++;
         end
         if (got.granted_frame !== exp.granted_frame) begin
            $error("granted_frame exp %0d got %0d", exp.granted_frame, got.granted_frame);
            errors++;
         end
         if (got.empty_count !== exp.empty_count) begin
            $error("empty_count exp %0d got %0d", exp.empty_count, got.empty_count); errors++;
         end
         if (got.ready_count !== exp.ready_count) begin
            $error("ready_count exp %0d got %0d", exp.ready_count, got.ready_count); errors++;
         end
         if (got.decoding_count !== exp.decoding_count) begin
            $error("decoding_count exp %0d got %0d", exp.decoding_count, got.decoding_count);
            errors++;
         end
         if (got.rendering_count !== exp.rendering_count) begin
            $error("rendering_count exp %0d got %0d", exp.rendering_count,
                   got.rendering_count);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_pool_size = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_opcode = '0;
   logic [6:0] req_frame_index = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_status;
   logic [6:0] rsp_granted_frame;
   logic [7:0] rsp_empty_count, rsp_ready_count, rsp_decoding_count, rsp_rendering_count;

   pool_scoreboard pool = new();
   bit  drain_quiet = 0;
   bit  hold_long = 0;
   int  idle_cycles = 0;
   int  items_sent = 0;

   always #4 clock = ~clock;

   four_list_frame_buffer_pool_top u_top (.*);

   // result checking at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         pool.check_report({rsp_status, rsp_granted_frame, rsp_empty_count,
                            rsp_ready_count, rsp_decoding_count, rsp_rendering_count});
   end

   // receiver stalls in bursts, or one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < 300; n++) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_long = 0;
            @(negedge clock);
         end else if (!drain_quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 11);
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", pool.pending.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // valid stays up after an accept until the next call or a drain takes it down
   task automatic send_request(fbp_pkg::op_type op, fbp_pkg::frame_type f, bit gaps);
      int n;
      if (gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 11);
         repeat (n) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_frame_index <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pool.note_request(op, f);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pool.pending.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_pool_size(logic [7:0] value);
      wait_drained();
      csr_valid     <= 1'b1;
      csr_pool_size <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pool.rebuild(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed traffic: pick a frame the opcode will accept
   task automatic send_random(bit gaps);
      fbp_pkg::op_type    op;
      fbp_pkg::frame_type f;
      int                 r;
      r  = $urandom_range(0, 99);
      op = fbp_pkg::op_type'($urandom_range(0, 3));
      f  = fbp_pkg::frame_type'($urandom_range(0, 127));
      if (r < 2) op = fbp_pkg::OP_RESET;
      else if (r < 5) op = fbp_pkg::op_type'($urandom_range(5, 7));
      else if (r < 85) begin
         if (op == fbp_pkg::OP_DEC_PUT && pool.lists[fbp_pkg::LIST_DEC].size() != 0)
            f = pool.lists[fbp_pkg::LIST_DEC][
                   $urandom_range(0, pool.lists[fbp_pkg::LIST_DEC].size() - 1)];
         if (op == fbp_pkg::OP_REN_PUT && pool.lists[fbp_pkg::LIST_REND].size() != 0)
            f = pool.lists[fbp_pkg::LIST_REND][
                   $urandom_range(0, pool.lists[fbp_pkg::LIST_REND].size() - 1)];
      end else if (r < 92)
         f = fbp_pkg::frame_type'($urandom_range(0, pool.pool_frames));
      send_request(op, f, gaps);
   endtask

   initial begin
      logic [7:0] sizes[6];
      sizes = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd5, 8'd129};
      pool.rebuild(fbp_pkg::POOL_RESET);
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: default pool of 16
      send_request(fbp_pkg::OP_DEC_PUT, 7'd3, 0);
      send_request(fbp_pkg::OP_REN_GET, 7'd0, 0);
      send_request(fbp_pkg::OP_REN_PUT, 7'd0, 0);
      for (int i = 0; i < 17; i++) send_request(fbp_pkg::OP_DEC_GET, 7'd0, 0);
      send_request(fbp_pkg::OP_DEC_PUT, 7'd15, 0);
      send_request(fbp_pkg::OP_DEC_PUT, 7'd16, 0);
      send_request(fbp_pkg::OP_DEC_PUT, 7'd127, 0);
      send_request(fbp_pkg::OP_REN_GET, 7'd0, 0);
      send_request(fbp_pkg::OP_REN_PUT, 7'd15, 0);
      send_request(fbp_pkg::OP_DEC_PUT, 7'd2, 0);
      send_request(fbp_pkg::OP_REN_GET, 7'd0, 0);
      send_request(fbp_pkg::op_type'(5), 7'h55, 0);
      send_request(fbp_pkg::op_type'(7), 7'h2a, 0);
      send_request(fbp_pkg::OP_RESET, 7'd0, 0);

      // random phases across pool sizes, extremes included
      foreach (sizes[k]) begin
         write_pool_size(sizes[k]);
         for (int i = 0; i < 250; i++) send_random(1);
         if (k == 1) begin
            hold_long = 1;
            for (int i = 0; i < 40; i++) send_random(0);
         end
         if (k == 3) wait_drained();
      end
      write_pool_size(8'd16);
      drain_quiet = 1;
      for (int i = 0; i < 250; i++) send_random(0);

      wait_drained();
      $display("sent %0d items over six pool sizes, %0d results checked, %0d failing ops",
               items_sent, pool.checked, pool.failures_seen);
      if (pool.errors == 0 && pool.pending.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

FILE: filelist.f
src/fbp_pkg.sv
src/fbp_ram.sv
src/fbp_ctrl.sv
src/four_list_frame_buffer_pool_top.sv
tb/four_list_frame_buffer_pool_top_tb.sv
